// ----- src/csem_pkg.sv -----
// Shared constants, types and helpers for the counting semaphore table unit.
`timescale 1ns / 1ps

package csem_pkg;

    // Table and queue sizes
    localparam int NUM_SEMAPHORES = 8;
    localparam int MAX_WAITERS    = 16;

    localparam int IDX_W       = $clog2(NUM_SEMAPHORES);
    localparam int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int STORE_DEPTH = NUM_SEMAPHORES * MAX_WAITERS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Field widths
    localparam int OP_W     = 2;
    localparam int NAME_W   = 8;
    localparam int PID_W    = 8;
    localparam int CNT_W    = 9;
    localparam int STATUS_W = 3;
    localparam int INIT_W   = 8;

    // Stream and register port widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register index, taken from paddr[APB_AW-1]
    localparam logic REG_INIT_COUNT = 1'b0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DECLARE = 2'd0;
    localparam logic [OP_W-1:0] OP_WAIT    = 2'd1;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

    // Count limits
    localparam logic signed [CNT_W-1:0] CNT_MAX   = 9'sd255;
    localparam logic signed [CNT_W-1:0] CNT_FLOOR = CNT_W'(-MAX_WAITERS);
    localparam logic signed [CNT_W-1:0] CNT_ONE   = 9'sd1;
    localparam logic signed [CNT_W-1:0] CNT_M_ONE = -9'sd1;

    // Shared arithmetic unit
    typedef enum logic {
        ALU_CMP,
        ALU_ADD
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t                 mode;
        logic signed [CNT_W-1:0]   a;
        logic signed [CNT_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic                      eq;
        logic signed [CNT_W-1:0]   sum;
    } alu_rsp_t;

    // Advance a queue pointer, wrapping at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_WAITERS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// ----- src/csem_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register the read word every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/csem_alu.sv -----
// Shared compare and add unit used by the name scan and the count update.
`timescale 1ns / 1ps

module csem_alu (
    input  csem_pkg::alu_req_t req,
    output csem_pkg::alu_rsp_t rsp
);

    import csem_pkg::*;

    // Compare names during the scan, add the count step during execute
    always_comb
    begin
        rsp.eq  = 1'b0;
        rsp.sum = '0;
        case (req.mode)
            ALU_CMP:
            begin
                rsp.eq = (req.a == req.b);
            end
            ALU_ADD:
            begin
                rsp.sum = req.a + req.b;
            end
            default:
            begin
                rsp.eq  = 1'b0;
                rsp.sum = '0;
            end
        endcase
    end

endmodule

// ----- src/counting_semaphore_table_unit.sv -----
// Counting semaphore table: name scan, count update and per-entry waiter queues.
// Path from acceptance to m_tvalid: a name scan of one table entry per cycle that stops at
//   the first match, one execute, a waiter read on a wake, and a load once the output is free.
// A new item is taken only once the last result is loaded: s_tready is high only while
//   idle, and the name scan runs through the single shared compare unit.
// Reset: table empty, queue pointers zero, initial_count 1; no clearing pass.
`timescale 1ns / 1ps

module counting_semaphore_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csem_pkg::APB_AW-1:0]    paddr,
    input  logic [csem_pkg::APB_DW-1:0]    pwdata,
    output logic [csem_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op [1:0], sem_name [9:2], process_id [17:10], zero [23:18]
    input  logic [csem_pkg::S_TDATA_W-1:0] s_tdata,
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [2:0], blocked [3], woken_valid [4], woken_process [12:5],
    // count_after [21:13], zero [23:22]
    output logic [csem_pkg::M_TDATA_W-1:0] m_tdata
);

    import csem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_READ,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;

    // Item being worked on
    logic [OP_W-1:0]         op_reg, op_next;
    logic [NAME_W-1:0]       name_reg, name_next;
    logic [PID_W-1:0]        pid_reg, pid_next;

    // Scan results
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                    free_reg, free_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    // Result being assembled
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    blocked_reg, blocked_next;
    logic                    woken_valid_reg, woken_valid_next;
    logic [PID_W-1:0]        woken_reg, woken_next;
    logic signed [CNT_W-1:0] count_after_reg, count_after_next;

    // Output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Configuration
    logic [INIT_W-1:0]       init_count_reg, init_count_next;

    // Semaphore table
    logic                    entry_valid_reg [NUM_SEMAPHORES];
    logic                    entry_valid_next [NUM_SEMAPHORES];
    logic [NAME_W-1:0]       entry_name_reg [NUM_SEMAPHORES];
    logic [NAME_W-1:0]       entry_name_next [NUM_SEMAPHORES];
    logic signed [CNT_W-1:0] entry_count_reg [NUM_SEMAPHORES];
    logic signed [CNT_W-1:0] entry_count_next [NUM_SEMAPHORES];
    logic [PTR_W-1:0]        q_head_reg [NUM_SEMAPHORES];
    logic [PTR_W-1:0]        q_head_next [NUM_SEMAPHORES];
    logic [PTR_W-1:0]        q_tail_reg [NUM_SEMAPHORES];
    logic [PTR_W-1:0]        q_tail_next [NUM_SEMAPHORES];

    // Shared unit and waiter memory
    alu_req_t                alu_req;
    alu_rsp_t                alu_rsp;
    logic                    ram_we;
    logic [STORE_AW-1:0]     ram_addr;
    logic [PID_W-1:0]        ram_rdata;

    logic                    in_accept;
    logic                    cfg_write;
    logic signed [CNT_W-1:0] cur_count;
    logic [PTR_W-1:0]        q_ptr;
    logic                    wake;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1] == REG_INIT_COUNT);
    assign prdata    = (paddr[APB_AW-1] == REG_INIT_COUNT)
                       ? {{(APB_DW-INIT_W){1'b0}}, init_count_reg} : '0;

    // Current entry values for the execute step
    assign cur_count = entry_count_reg[hit_idx_reg];
    assign q_ptr     = (op_reg == OP_WAIT) ? q_tail_reg[hit_idx_reg]
                                           : q_head_reg[hit_idx_reg];
    assign ram_addr  = STORE_AW'(hit_idx_reg) * STORE_AW'(MAX_WAITERS) + STORE_AW'(q_ptr);

    // Feed the shared unit: name compare while scanning, count step otherwise
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            alu_req.mode = ALU_CMP;
            alu_req.a    = $signed({1'b0, entry_name_reg[scan_idx_reg]});
            alu_req.b    = $signed({1'b0, name_reg});
        end
        else
        begin
            alu_req.mode = ALU_ADD;
            alu_req.a    = cur_count;
            alu_req.b    = (op_reg == OP_WAIT) ? CNT_M_ONE : CNT_ONE;
        end
    end

    csem_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    csem_ram #(
        .WIDTH (PID_W),
        .DEPTH (STORE_DEPTH)
    ) u_waiters (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pid_reg),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        name_next        = name_reg;
        pid_next         = pid_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        status_next      = status_reg;
        blocked_next     = blocked_reg;
        woken_valid_next = woken_valid_reg;
        woken_next       = woken_reg;
        count_after_next = count_after_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        init_count_next  = init_count_reg;
        entry_valid_next = entry_valid_reg;
        entry_name_next  = entry_name_reg;
        entry_count_next = entry_count_reg;
        q_head_next      = q_head_reg;
        q_tail_next      = q_tail_reg;
        ram_we           = 1'b0;
        wake             = 1'b0;

        if (cfg_write)
        begin
            init_count_next = pwdata[INIT_W-1:0];
        end

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = s_tdata[OP_W-1:0];
                    name_next     = s_tdata[OP_W+NAME_W-1:OP_W];
                    pid_next      = s_tdata[OP_W+NAME_W+PID_W-1:OP_W+NAME_W];
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    hit_idx_next  = '0;
                    free_next     = 1'b0;
                    free_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One entry per cycle; stop at the first match
                if (entry_valid_reg[scan_idx_reg] && alu_rsp.eq)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                    state_next   = S_EXEC;
                end
                else
                begin
                    if (!entry_valid_reg[scan_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = scan_idx_reg;
                    end
                    if (scan_idx_reg == IDX_W'(NUM_SEMAPHORES - 1))
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            S_EXEC:
            begin
                status_next      = ST_OK;
                blocked_next     = 1'b0;
                woken_valid_next = 1'b0;
                woken_next       = '0;
                count_after_next = '0;
                case (op_reg)
                    OP_DECLARE:
                    begin
                        if (hit_reg)
                        begin
                            count_after_next = cur_count;
                        end
                        else if (free_reg)
                        begin
                            entry_valid_next[free_idx_reg] = 1'b1;
                            entry_name_next[free_idx_reg]  = name_reg;
                            entry_count_next[free_idx_reg] =
                                $signed({1'b0, init_count_reg});
                            q_head_next[free_idx_reg]      = '0;
                            q_tail_next[free_idx_reg]      = '0;
                            count_after_next = $signed({1'b0, init_count_reg});
                        end
                        else
                        begin
                            status_next = ST_TABLE_FULL;
                        end
                    end
                    OP_WAIT:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_UNKNOWN;
                        end
                        else if (cur_count <= CNT_FLOOR)
                        begin
                            status_next      = ST_QUEUE_FULL;
                            count_after_next = cur_count;
                        end
                        else
                        begin
                            entry_count_next[hit_idx_reg] = alu_rsp.sum;
                            count_after_next              = alu_rsp.sum;
                            // Queue the caller when the count went negative
                            if (alu_rsp.sum[CNT_W-1])
                            begin
                                ram_we                   = 1'b1;
                                q_tail_next[hit_idx_reg] = ptr_inc(q_ptr);
                                blocked_next             = 1'b1;
                            end
                        end
                    end
                    OP_SIGNAL:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_UNKNOWN;
                        end
                        else if (cur_count >= CNT_MAX)
                        begin
                            status_next      = ST_SATURATED;
                            count_after_next = cur_count;
                        end
                        else
                        begin
                            entry_count_next[hit_idx_reg] = alu_rsp.sum;
                            count_after_next              = alu_rsp.sum;
                            // Release the head waiter while the count stays at or below zero
                            if (alu_rsp.sum[CNT_W-1] || (alu_rsp.sum == '0))
                            begin
                                wake                     = 1'b1;
                                q_head_next[hit_idx_reg] = ptr_inc(q_ptr);
                                woken_valid_next         = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_UNKNOWN;
                    end
                endcase
                state_next = wake ? S_READ : S_DONE;
            end

            S_READ:
            begin
                woken_next = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, count_after_reg, woken_reg,
                                     woken_valid_reg, blocked_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            init_count_reg <= INIT_W'(1);
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
                q_head_reg[i]      <= '0;
                q_tail_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            init_count_reg   <= init_count_next;
            entry_valid_reg  <= entry_valid_next;
            q_head_reg       <= q_head_next;
            q_tail_reg       <= q_tail_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        name_reg         <= name_next;
        pid_reg          <= pid_next;
        scan_idx_reg     <= scan_idx_next;
        hit_reg          <= hit_next;
        hit_idx_reg      <= hit_idx_next;
        free_reg         <= free_next;
        free_idx_reg     <= free_idx_next;
        status_reg       <= status_next;
        blocked_reg      <= blocked_next;
        woken_valid_reg  <= woken_valid_next;
        woken_reg        <= woken_next;
        count_after_reg  <= count_after_next;
        entry_name_reg   <= entry_name_next;
        entry_count_reg  <= entry_count_next;
    end

endmodule
